// ===== rtl/core/kdpc_pkg.sv =====
package kdpc_pkg;

    // Key bank and event queue geometry
    localparam int KEYS        = 4;
    localparam int QUEUE_SLOTS = 4;
    localparam int PTR_W       = $clog2(QUEUE_SLOTS);
    // Wide enough for a queue count plus one release per key
    localparam int CNT_W       = $clog2(QUEUE_SLOTS + KEYS + 1);

    // Field widths
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int KEY_W    = 2;
    localparam int COUNT_W  = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;

    // Register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [CFG_W-1:0] LONG_RST     = 16'd800;
    localparam logic [KEYS-1:0]  POLARITY_RST = 4'd1;

    // Request kinds carried in tuser
    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_LONG     = 2'd1,
        REG_POLARITY = 2'd2
    } t_reg_idx;

    // What one key lane reports for the current scan
    typedef struct packed {
        logic release_evt;
        logic is_long;
    } t_lane_evt;

    // One result item
    typedef struct packed {
        logic               event_valid;
        logic [KEY_W-1:0]   event_key;
        logic               event_long;
        logic [COUNT_W-1:0] queue_count;
    } t_result;

endpackage

// ===== rtl/core/kdpc_lane.sv =====
module kdpc_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_scan,
    input  logic [kdpc_pkg::TIME_W-1:0]   i_now_ms,
    input  logic                          i_level,
    input  logic                          i_high_active,
    input  logic [kdpc_pkg::CFG_W-1:0]    i_settle_ms,
    input  logic [kdpc_pkg::CFG_W-1:0]    i_long_press_ms,
    output kdpc_pkg::t_lane_evt           o_evt
);
    import kdpc_pkg::*;

    logic              r_down;
    logic [TIME_W-1:0] r_press_time;
    logic [TIME_W-1:0] r_last_edge;

    logic              w_pressed;
    logic [TIME_W-1:0] w_since_edge;
    logic [TIME_W-1:0] w_held;
    logic              w_take;

    assign w_pressed    = i_high_active ? i_level : ~i_level;
    // Modulo 2^32 differences
    assign w_since_edge = i_now_ms - r_last_edge;
    assign w_held       = i_now_ms - r_press_time;
    assign w_take       = i_scan && (w_pressed != r_down)
                       && (w_since_edge >= {{(TIME_W-CFG_W){1'b0}}, i_settle_ms});

    assign o_evt.release_evt = w_take && !w_pressed;
    assign o_evt.is_long     = (w_held >= {{(TIME_W-CFG_W){1'b0}}, i_long_press_ms});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down       <= 1'b0;
            r_press_time <= '0;
            r_last_edge  <= '0;
        end else if (w_take) begin
            r_down      <= w_pressed;
            r_last_edge <= i_now_ms;
            if (w_pressed) begin
                r_press_time <= i_now_ms;
            end
        end
    end

endmodule

// ===== rtl/core/kdpc_merge.sv =====
module kdpc_merge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_scan,
    input  logic                  i_pop,
    input  kdpc_pkg::t_lane_evt   i_evt [kdpc_pkg::KEYS],
    output kdpc_pkg::t_result     o_res
);
    import kdpc_pkg::*;

    localparam logic [CNT_W-1:0] SLOTS = CNT_W'(QUEUE_SLOTS);

    logic [KEY_W:0]       r_ring [QUEUE_SLOTS];
    logic [PTR_W-1:0]     r_head;
    logic [PTR_W-1:0]     r_tail;

    logic [CNT_W-1:0]     w_count;
    logic [CNT_W-1:0]     w_free;
    logic [CNT_W-1:0]     w_pushed;
    logic                 w_we    [KEYS];
    logic [PTR_W-1:0]     w_waddr [KEYS];
    logic [PTR_W-1:0]     w_head_next;
    logic [PTR_W-1:0]     w_tail_next;
    logic                 w_pop_take;
    logic [KEY_W:0]       w_entry;

    always_comb begin
        if (r_head >= r_tail) begin
            w_count = CNT_W'(r_head) - CNT_W'(r_tail);
        end else begin
            w_count = CNT_W'(r_head) + SLOTS - CNT_W'(r_tail);
        end
        w_free = SLOTS - CNT_W'(1) - w_count;
    end

    // Rank releases in key order; drop those beyond the free slots
    always_comb begin
        logic [CNT_W-1:0] acc;
        logic [CNT_W-1:0] sum;
        acc = '0;
        for (int k = 0; k < KEYS; k++) begin
            w_we[k] = i_scan && i_evt[k].release_evt && (acc < w_free);
            sum = CNT_W'(r_head) + acc;
            if (sum >= SLOTS) begin
                sum = sum - SLOTS;
            end
            w_waddr[k] = sum[PTR_W-1:0];
            if (w_we[k]) begin
                acc = acc + CNT_W'(1);
            end
        end
        w_pushed = acc;
        sum = CNT_W'(r_head) + acc;
        if (sum >= SLOTS) begin
            sum = sum - SLOTS;
        end
        w_head_next = sum[PTR_W-1:0];
    end

    assign w_pop_take  = i_pop && (r_head != r_tail);
    assign w_tail_next = (r_tail == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : r_tail + PTR_W'(1);
    assign w_entry     = r_ring[r_tail];

    always_comb begin
        o_res.event_valid = w_pop_take;
        o_res.event_key   = w_pop_take ? w_entry[KEY_W:1] : '0;
        o_res.event_long  = w_pop_take && w_entry[0];
        if (i_scan) begin
            o_res.queue_count = COUNT_W'(w_count + w_pushed);
        end else begin
            o_res.queue_count = COUNT_W'(w_count - CNT_W'(w_pop_take));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < KEYS; k++) begin
            if (w_we[k]) begin
                r_ring[w_waddr[k]] <= {KEY_W'(k), i_evt[k].is_long};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            if (i_scan) begin
                r_head <= w_head_next;
            end
            if (w_pop_take) begin
                r_tail <= w_tail_next;
            end
        end
    end

endmodule

// ===== rtl/core/key_debounce_press_classifier.sv =====
// Debounce and short/long press classifier for a bank of four push keys.
//
// Request channel (i_s_*): tuser selects scan or pop. A scan carries the
// millisecond tick and raw pin levels; each key lane applies its polarity
// bit, accepts a level change only once the debounce time has passed since
// its last accepted edge (modulo 2^32), and on release classifies the press.
// Releases enter a four-slot event ring in key order; at most three events
// wait, later ones are dropped. A pop returns the oldest event.
// Result channel (o_m_*): exactly one result per request, in order.
// Configuration channel (i_cfg_*): always ready, written while idle.
//
// Results are registered (output register, or skid entry on a stall).
// Throughput: one request per cycle while o_s_tready is high; all lanes and the
// ring update finish in that cycle. An output register plus one skid entry let
// a request be taken while a result waits; with both full, o_s_tready drops
// until the receiver takes a result. Reset (synchronous, active low) releases
// all keys, clears timestamps and the ring pointers, and loads the default
// debounce (20 ms), long press (800 ms) and polarity (key 0 active high).
module key_debounce_press_classifier (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Requests
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [kdpc_pkg::IN_DATA_W-1:0]      i_s_tdata,  // now_ms[31:0], key_levels[35:32]
    input  logic                                i_s_tuser,  // req_type
    // Results
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [kdpc_pkg::OUT_DATA_W-1:0]     o_m_tdata,  // event_key[1:0], event_long[2],
                                                            // queue_count[4:3]
    output logic                                o_m_tuser,  // event_valid
    // Configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kdpc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [kdpc_pkg::CFG_W-1:0]          i_cfg_data
);
    import kdpc_pkg::*;

    // Configuration registers
    logic [CFG_W-1:0]  r_settle_ms;
    logic [CFG_W-1:0]  r_long_press_ms;
    logic [KEYS-1:0]   r_polarity;

    // Output register and skid entry
    logic              r_out_valid;
    t_result           r_out;
    logic              r_skid_valid;
    t_result           r_skid;

    logic              w_in_fire;
    logic              w_out_fire;
    logic              w_scan;
    logic              w_pop;
    logic [TIME_W-1:0] w_now_ms;
    logic [KEYS-1:0]   w_levels;
    t_lane_evt         w_evt [KEYS];
    t_result           w_res;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_skid_valid;
    assign w_in_fire   = i_s_tvalid && o_s_tready;
    assign w_out_fire  = r_out_valid && i_m_tready;
    assign w_scan      = w_in_fire && (i_s_tuser == REQ_SCAN);
    assign w_pop       = w_in_fire && (i_s_tuser == REQ_POP);
    assign w_now_ms    = i_s_tdata[TIME_W-1:0];
    assign w_levels    = i_s_tdata[TIME_W +: KEYS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ms     <= DEBOUNCE_RST;
            r_long_press_ms <= LONG_RST;
            r_polarity      <= POLARITY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_DEBOUNCE: r_settle_ms     <= i_cfg_data;
                REG_LONG:     r_long_press_ms <= i_cfg_data;
                REG_POLARITY: r_polarity      <= i_cfg_data[KEYS-1:0];
                default:      ;  // drop writes beyond the register list
            endcase
        end
    end

    // One lane per key, all qualified in the same cycle
    for (genvar k = 0; k < KEYS; k++) begin : g_lane
        kdpc_lane u_lane (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_scan          (w_scan),
            .i_now_ms        (w_now_ms),
            .i_level         (w_levels[k]),
            .i_high_active   (r_polarity[k]),
            .i_settle_ms     (r_settle_ms),
            .i_long_press_ms (r_long_press_ms),
            .o_evt           (w_evt[k])
        );
    end

    // Merge lane releases into the event ring and serve pops
    kdpc_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scan  (w_scan),
        .i_pop   (w_pop),
        .i_evt   (w_evt),
        .o_res   (w_res)
    );

    // Output register with skid entry: refill from skid first, else from
    // the new request; hold the new result in skid while the output stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_in_fire;
            end
        end else if (w_in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_in_fire) begin
                r_out <= w_res;
            end
        end else if (w_in_fire) begin
            r_skid <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.event_valid;
    assign o_m_tdata  = {{(OUT_DATA_W-KEY_W-1-COUNT_W){1'b0}},
                         r_out.queue_count, r_out.event_long, r_out.event_key};

    // A skid entry only exists behind a waiting output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output result");

    // A scan never returns an event
    a_scan_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan |-> !w_res.event_valid)
        else $error("scan request produced an event");

    // A pop that finds nothing reports an empty queue
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_res.event_valid) |-> (w_res.queue_count == '0))
        else $error("empty pop reported a nonzero count");

    // A result taken with the skid full moves the skid entry into the output
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_m_tready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry not drained after output was taken");

endmodule
